@@ design/usc_pkg.sv @@
// ----------------------------------------------------------------------------
// usc_pkg
// Shared constants for the unique sink component size block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usc_pkg;

    localparam int FIELD_W       = 11;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

endpackage

`default_nettype wire

@@ design/usc_edge_store.sv @@
// ----------------------------------------------------------------------------
// usc_edge_store
// Edge target and next-link memories, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usc_edge_store #(
    parameter int MAX_EDGES = usc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                               clk,
    input  wire logic                               tgt_we,
    input  wire logic [$clog2(MAX_EDGES)-1:0]       tgt_waddr,
    input  wire logic [usc_pkg::FIELD_W-1:0]        tgt_wdata,
    input  wire logic                               lnk_we,
    input  wire logic [$clog2(MAX_EDGES)-1:0]       lnk_waddr,
    input  wire logic [$clog2(MAX_EDGES+1)-1:0]     lnk_wdata,
    input  wire logic [$clog2(MAX_EDGES)-1:0]       raddr,
    output logic      [usc_pkg::FIELD_W-1:0]        rtgt,
    output logic      [$clog2(MAX_EDGES+1)-1:0]     rlink
);

    localparam int LW = $clog2(MAX_EDGES + 1);

    logic [usc_pkg::FIELD_W-1:0] tgt_mem [MAX_EDGES];
    logic [LW-1:0]               lnk_mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        rtgt <= tgt_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        rlink <= lnk_mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/usc_node_store.sv @@
// ----------------------------------------------------------------------------
// usc_node_store
// Per-node list heads, per-node search state and per-component tallies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usc_node_store #(
    parameter int MAX_NODES = usc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = usc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                               clk,
    input  wire logic                               fst_we,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     fst_waddr,
    input  wire logic [$clog2(MAX_EDGES+1)-1:0]     fst_wdata,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     fst_raddr,
    output logic      [$clog2(MAX_EDGES+1)-1:0]     fst_rdata,
    input  wire logic                               nd_we,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     nd_waddr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     nd_wvisit,
    input  wire logic                               nd_wonstk,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     nd_wcomp,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     nd_raddr,
    output logic      [$clog2(MAX_NODES+1)-1:0]     nd_rvisit,
    output logic                                    nd_ronstk,
    output logic      [$clog2(MAX_NODES+1)-1:0]     nd_rcomp,
    input  wire logic                               cm_we,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     cm_waddr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     cm_wsize,
    input  wire logic [$clog2(MAX_EDGES+1)-1:0]     cm_wout,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     cm_raddr,
    output logic      [$clog2(MAX_NODES+1)-1:0]     cm_rsize,
    output logic      [$clog2(MAX_EDGES+1)-1:0]     cm_rout
);

    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int LW    = $clog2(MAX_EDGES + 1);
    localparam int DEPTH = MAX_NODES + 1;

    logic [LW-1:0]       fst_mem [DEPTH];
    logic [2*NW:0]       nd_mem  [DEPTH];
    logic [NW+LW-1:0]    cm_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (fst_we)
        begin
            fst_mem[fst_waddr] <= fst_wdata;
        end
        fst_rdata <= fst_mem[fst_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            nd_mem[nd_waddr] <= {nd_wvisit, nd_wonstk, nd_wcomp};
        end
        {nd_rvisit, nd_ronstk, nd_rcomp} <= nd_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cm_mem[cm_waddr] <= {cm_wsize, cm_wout};
        end
        {cm_rsize, cm_rout} <= cm_mem[cm_raddr];
    end

endmodule

`default_nettype wire

@@ design/usc_stack_store.sv @@
// ----------------------------------------------------------------------------
// usc_stack_store
// Search stack and call frame memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usc_stack_store #(
    parameter int MAX_NODES = usc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = usc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                               clk,
    input  wire logic                               ss_we,
    input  wire logic [$clog2(MAX_NODES)-1:0]       ss_waddr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     ss_wnode,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     ss_wvisit,
    input  wire logic [$clog2(MAX_NODES)-1:0]       ss_raddr,
    output logic      [$clog2(MAX_NODES+1)-1:0]     ss_rnode,
    output logic      [$clog2(MAX_NODES+1)-1:0]     ss_rvisit,
    input  wire logic                               fr_we,
    input  wire logic [$clog2(MAX_NODES)-1:0]       fr_waddr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     fr_wnode,
    input  wire logic [$clog2(MAX_EDGES+1)-1:0]     fr_wcur,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     fr_wlow,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]     fr_wvisit,
    input  wire logic [$clog2(MAX_NODES)-1:0]       fr_raddr,
    output logic      [$clog2(MAX_NODES+1)-1:0]     fr_rnode,
    output logic      [$clog2(MAX_EDGES+1)-1:0]     fr_rcur,
    output logic      [$clog2(MAX_NODES+1)-1:0]     fr_rlow,
    output logic      [$clog2(MAX_NODES+1)-1:0]     fr_rvisit
);

    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(MAX_EDGES + 1);

    logic [2*NW-1:0]    ss_mem [MAX_NODES];
    logic [3*NW+LW-1:0] fr_mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (ss_we)
        begin
            ss_mem[ss_waddr] <= {ss_wnode, ss_wvisit};
        end
        {ss_rnode, ss_rvisit} <= ss_mem[ss_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            fr_mem[fr_waddr] <= {fr_wnode, fr_wcur, fr_wlow, fr_wvisit};
        end
        {fr_rnode, fr_rcur, fr_rlow, fr_rvisit} <= fr_mem[fr_raddr];
    end

endmodule

`default_nettype wire

@@ design/unique_sink_component_size.sv @@
// ----------------------------------------------------------------------------
// unique_sink_component_size
// Edge add transactions build per-node edge lists; a finish transaction runs a
// strongly connected component search and returns the node count of the only
// sink component (0 if there are none or several) with the dropped-edge flag.
// An add leaves the block idle, so a new transaction can follow at once. A
// finish walks memories with one read port each and registered read data: the
// search, then the component tally, then the sink scan, then a clearing pass
// over all MAX_NODES+1 node entries before the next transaction. The same
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unique_sink_component_size #(
    parameter int MAX_NODES = usc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = usc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [usc_pkg::FIELD_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic [usc_pkg::FIELD_W-1:0]    source_node,
    input  wire logic [usc_pkg::FIELD_W-1:0]    target_node,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [usc_pkg::FIELD_W-1:0]    sink_size,
    output logic                                edges_dropped
);

    localparam int FW = usc_pkg::FIELD_W;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int SW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int LW = $clog2(MAX_EDGES + 1);
    localparam logic [NW-1:0] MAXN = NW'(MAX_NODES);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_SCAN    = 5'd2;
    localparam logic [4:0] S_SCAN_W  = 5'd3;
    localparam logic [4:0] S_ENTER   = 5'd4;
    localparam logic [4:0] S_ENTER_W = 5'd5;
    localparam logic [4:0] S_STEP    = 5'd6;
    localparam logic [4:0] S_EDGE_W  = 5'd7;
    localparam logic [4:0] S_NBR_W   = 5'd8;
    localparam logic [4:0] S_FIN     = 5'd9;
    localparam logic [4:0] S_POP     = 5'd10;
    localparam logic [4:0] S_POP_W   = 5'd11;
    localparam logic [4:0] S_RET     = 5'd12;
    localparam logic [4:0] S_RET_W   = 5'd13;
    localparam logic [4:0] S_CNT_V   = 5'd14;
    localparam logic [4:0] S_CNT_VW  = 5'd15;
    localparam logic [4:0] S_CNT_LD  = 5'd16;
    localparam logic [4:0] S_CNT_E   = 5'd17;
    localparam logic [4:0] S_CNT_EW  = 5'd18;
    localparam logic [4:0] S_CNT_NW  = 5'd19;
    localparam logic [4:0] S_SK      = 5'd20;
    localparam logic [4:0] S_SK_W    = 5'd21;
    localparam logic [4:0] S_OUT     = 5'd22;

    logic [4:0]    state_reg, state_next;
    logic [FW-1:0] ncount_reg;
    logic [NW-1:0] clr_reg, clr_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic          drop_reg, drop_next;
    logic          pend_reg, pend_next;
    logic [NW-1:0] pend_src_reg, pend_src_next;
    logic [EW-1:0] pend_edge_reg, pend_edge_next;
    logic          fwd_reg, fwd_next;
    logic [LW-1:0] fwd_link_reg, fwd_link_next;
    logic [NW:0]   vscan_reg, vscan_next;
    logic [NW-1:0] ent_reg, ent_next;
    logic          top_vld_reg, top_vld_next;
    logic [NW-1:0] top_node_reg, top_node_next;
    logic [LW-1:0] top_cur_reg, top_cur_next;
    logic [NW-1:0] top_low_reg, top_low_next;
    logic [NW-1:0] top_vis_reg, top_vis_next;
    logic [NW-1:0] vcnt_reg, vcnt_next;
    logic [NW-1:0] ccnt_reg, ccnt_next;
    logic [NW-1:0] ssp_reg, ssp_next;
    logic [NW-1:0] fsp_reg, fsp_next;
    logic [NW-1:0] nbr_reg, nbr_next;
    logic [NW-1:0] cv_reg, cv_next;
    logic [LW-1:0] ccur_reg, ccur_next;
    logic [NW-1:0] csize_reg, csize_next;
    logic [LW-1:0] cout_reg, cout_next;
    logic [1:0]    sink_reg, sink_next;
    logic [NW-1:0] last_reg, last_next;
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] out_size_reg, out_size_next;
    logic          out_drop_reg, out_drop_next;

    logic [NW-1:0] n;
    logic          in_accept;
    logic          src_ok, dst_ok, tgt_ok;

    logic          tgt_we, lnk_we;
    logic [EW-1:0] tgt_waddr, lnk_waddr, ed_raddr;
    logic [FW-1:0] tgt_wdata, ed_rtgt;
    logic [LW-1:0] lnk_wdata, ed_rlink;

    logic          fst_we;
    logic [NW-1:0] fst_waddr, fst_raddr;
    logic [LW-1:0] fst_wdata, fst_rdata;
    logic          nd_we, nd_wonstk, nd_ronstk;
    logic [NW-1:0] nd_waddr, nd_wvisit, nd_wcomp, nd_raddr, nd_rvisit, nd_rcomp;
    logic          cm_we;
    logic [NW-1:0] cm_waddr, cm_wsize, cm_raddr, cm_rsize;
    logic [LW-1:0] cm_wout, cm_rout;

    logic          ss_we, fr_we;
    logic [SW-1:0] ss_waddr, ss_raddr, fr_waddr, fr_raddr;
    logic [NW-1:0] ss_wnode, ss_wvisit, ss_rnode, ss_rvisit;
    logic [NW-1:0] fr_wnode, fr_wlow, fr_wvisit, fr_rnode, fr_rlow, fr_rvisit;
    logic [LW-1:0] fr_wcur, fr_rcur;

    usc_edge_store #(.MAX_EDGES(MAX_EDGES)) u_edge (
        .clk(clk), .tgt_we(tgt_we), .tgt_waddr(tgt_waddr), .tgt_wdata(tgt_wdata),
        .lnk_we(lnk_we), .lnk_waddr(lnk_waddr), .lnk_wdata(lnk_wdata),
        .raddr(ed_raddr), .rtgt(ed_rtgt), .rlink(ed_rlink)
    );

    usc_node_store #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_node (
        .clk(clk),
        .fst_we(fst_we), .fst_waddr(fst_waddr), .fst_wdata(fst_wdata),
        .fst_raddr(fst_raddr), .fst_rdata(fst_rdata),
        .nd_we(nd_we), .nd_waddr(nd_waddr), .nd_wvisit(nd_wvisit),
        .nd_wonstk(nd_wonstk), .nd_wcomp(nd_wcomp), .nd_raddr(nd_raddr),
        .nd_rvisit(nd_rvisit), .nd_ronstk(nd_ronstk), .nd_rcomp(nd_rcomp),
        .cm_we(cm_we), .cm_waddr(cm_waddr), .cm_wsize(cm_wsize), .cm_wout(cm_wout),
        .cm_raddr(cm_raddr), .cm_rsize(cm_rsize), .cm_rout(cm_rout)
    );

    usc_stack_store #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_stack (
        .clk(clk),
        .ss_we(ss_we), .ss_waddr(ss_waddr), .ss_wnode(ss_wnode),
        .ss_wvisit(ss_wvisit), .ss_raddr(ss_raddr), .ss_rnode(ss_rnode),
        .ss_rvisit(ss_rvisit),
        .fr_we(fr_we), .fr_waddr(fr_waddr), .fr_wnode(fr_wnode), .fr_wcur(fr_wcur),
        .fr_wlow(fr_wlow), .fr_wvisit(fr_wvisit), .fr_raddr(fr_raddr),
        .fr_rnode(fr_rnode), .fr_rcur(fr_rcur), .fr_rlow(fr_rlow),
        .fr_rvisit(fr_rvisit)
    );

    always_comb
    begin
        if (32'(ncount_reg) > MAX_NODES)
        begin
            n = MAXN;
        end
        else
        begin
            n = NW'(ncount_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign src_ok    = (source_node != '0) && (32'(source_node) <= 32'(n));
    assign dst_ok    = (target_node != '0) && (32'(target_node) <= 32'(n));
    assign tgt_ok    = (ed_rtgt != '0) && (32'(ed_rtgt) <= 32'(n));

    assign out_valid     = out_valid_reg;
    assign sink_size     = out_size_reg;
    assign edges_dropped = out_drop_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        pend_next      = 1'b0;
        pend_src_next  = pend_src_reg;
        pend_edge_next = pend_edge_reg;
        fwd_next       = 1'b0;
        fwd_link_next  = fwd_link_reg;
        vscan_next     = vscan_reg;
        ent_next       = ent_reg;
        top_vld_next   = top_vld_reg;
        top_node_next  = top_node_reg;
        top_cur_next   = top_cur_reg;
        top_low_next   = top_low_reg;
        top_vis_next   = top_vis_reg;
        vcnt_next      = vcnt_reg;
        ccnt_next      = ccnt_reg;
        ssp_next       = ssp_reg;
        fsp_next       = fsp_reg;
        nbr_next       = nbr_reg;
        cv_next        = cv_reg;
        ccur_next      = ccur_reg;
        csize_next     = csize_reg;
        cout_next      = cout_reg;
        sink_next      = sink_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_size_next  = out_size_reg;
        out_drop_next  = out_drop_reg;

        tgt_we    = 1'b0;
        tgt_waddr = EW'(fill_reg);
        tgt_wdata = target_node;
        lnk_we    = 1'b0;
        lnk_waddr = pend_edge_reg;
        lnk_wdata = fwd_reg ? fwd_link_reg : fst_rdata;
        ed_raddr  = EW'(top_cur_reg - LW'(1));
        fst_we    = 1'b0;
        fst_waddr = pend_src_reg;
        fst_wdata = LW'(pend_edge_reg) + LW'(1);
        fst_raddr = NW'(source_node);
        nd_we     = 1'b0;
        nd_waddr  = ent_reg;
        nd_wvisit = vcnt_reg + NW'(1);
        nd_wonstk = 1'b1;
        nd_wcomp  = '0;
        nd_raddr  = vscan_reg[NW-1:0];
        cm_we     = 1'b0;
        cm_waddr  = cv_reg;
        cm_wsize  = csize_reg + NW'(1);
        cm_wout   = cout_reg;
        cm_raddr  = nd_rcomp;
        ss_we     = 1'b0;
        ss_waddr  = SW'(ssp_reg);
        ss_wnode  = ent_reg;
        ss_wvisit = vcnt_reg + NW'(1);
        ss_raddr  = SW'(ssp_reg - NW'(1));
        fr_we     = 1'b0;
        fr_waddr  = SW'(fsp_reg);
        fr_wnode  = top_node_reg;
        fr_wcur   = top_cur_reg;
        fr_wlow   = top_low_reg;
        fr_wvisit = top_vis_reg;
        fr_raddr  = SW'(fsp_reg - NW'(1));

        // finish the list link of the previous add
        if (pend_reg)
        begin
            fst_we = 1'b1;
            lnk_we = 1'b1;
        end

        case (state_reg)
            S_CLEAR:
            begin
                fst_we    = 1'b1;
                fst_waddr = clr_reg;
                fst_wdata = '0;
                nd_we     = 1'b1;
                nd_waddr  = clr_reg;
                nd_wvisit = '0;
                nd_wonstk = 1'b0;
                cm_we     = 1'b1;
                cm_waddr  = clr_reg;
                cm_wsize  = '0;
                cm_wout   = '0;
                clr_next  = clr_reg + NW'(1);
                if (clr_reg == MAXN)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == usc_pkg::CMD_FINISH)
                    begin
                        state_next   = S_SCAN;
                        vscan_next   = (NW+1)'(1);
                        vcnt_next    = '0;
                        ccnt_next    = '0;
                        ssp_next     = '0;
                        fsp_next     = '0;
                        top_vld_next = 1'b0;
                    end
                    else if ((32'(fill_reg) < MAX_EDGES) && src_ok && dst_ok)
                    begin
                        tgt_we         = 1'b1;
                        pend_next      = 1'b1;
                        pend_src_next  = NW'(source_node);
                        pend_edge_next = EW'(fill_reg);
                        fwd_next       = pend_reg && (pend_src_reg == NW'(source_node));
                        fwd_link_next  = LW'(pend_edge_reg) + LW'(1);
                        fill_next      = fill_reg + LW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (vscan_reg > {1'b0, n})
                begin
                    vscan_next = (NW+1)'(1);
                    state_next = S_CNT_V;
                end
                else
                begin
                    state_next = S_SCAN_W;
                end
            end
            S_SCAN_W:
            begin
                if (nd_rvisit == '0)
                begin
                    ent_next   = vscan_reg[NW-1:0];
                    state_next = S_ENTER;
                end
                else
                begin
                    vscan_next = vscan_reg + (NW+1)'(1);
                    state_next = S_SCAN;
                end
            end
            S_ENTER:
            begin
                fst_raddr = ent_reg;
                nd_we     = 1'b1;
                ss_we     = 1'b1;
                ssp_next  = ssp_reg + NW'(1);
                if (top_vld_reg)
                begin
                    fr_we    = 1'b1;
                    fsp_next = fsp_reg + NW'(1);
                end
                vcnt_next     = vcnt_reg + NW'(1);
                top_vld_next  = 1'b1;
                top_node_next = ent_reg;
                top_vis_next  = vcnt_reg + NW'(1);
                top_low_next  = vcnt_reg + NW'(1);
                state_next    = S_ENTER_W;
            end
            S_ENTER_W:
            begin
                top_cur_next = fst_rdata;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                if (top_cur_reg != '0)
                begin
                    state_next = S_EDGE_W;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EDGE_W:
            begin
                top_cur_next = ed_rlink;
                nd_raddr     = NW'(ed_rtgt);
                nbr_next     = NW'(ed_rtgt);
                state_next   = tgt_ok ? S_NBR_W : S_STEP;
            end
            S_NBR_W:
            begin
                if (nd_rvisit == '0)
                begin
                    ent_next   = nbr_reg;
                    state_next = S_ENTER;
                end
                else
                begin
                    if (nd_ronstk && (nd_rvisit < top_low_reg))
                    begin
                        top_low_next = nd_rvisit;
                    end
                    state_next = S_STEP;
                end
            end
            S_FIN:
            begin
                if (top_low_reg == top_vis_reg)
                begin
                    ccnt_next  = ccnt_reg + NW'(1);
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_POP:
            begin
                ssp_next   = ssp_reg - NW'(1);
                state_next = S_POP_W;
            end
            S_POP_W:
            begin
                nd_we      = 1'b1;
                nd_waddr   = ss_rnode;
                nd_wvisit  = ss_rvisit;
                nd_wonstk  = 1'b0;
                nd_wcomp   = ccnt_reg;
                state_next = (ss_rnode == top_node_reg) ? S_RET : S_POP;
            end
            S_RET:
            begin
                if (fsp_reg == '0)
                begin
                    top_vld_next = 1'b0;
                    vscan_next   = vscan_reg + (NW+1)'(1);
                    state_next   = S_SCAN;
                end
                else
                begin
                    fsp_next   = fsp_reg - NW'(1);
                    state_next = S_RET_W;
                end
            end
            S_RET_W:
            begin
                top_node_next = fr_rnode;
                top_cur_next  = fr_rcur;
                top_vis_next  = fr_rvisit;
                top_low_next  = (top_low_reg < fr_rlow) ? top_low_reg : fr_rlow;
                state_next    = S_STEP;
            end
            S_CNT_V:
            begin
                fst_raddr = vscan_reg[NW-1:0];
                if (vscan_reg > {1'b0, n})
                begin
                    vscan_next = (NW+1)'(1);
                    sink_next  = 2'd0;
                    state_next = S_SK;
                end
                else
                begin
                    state_next = S_CNT_VW;
                end
            end
            S_CNT_VW:
            begin
                cv_next    = nd_rcomp;
                ccur_next  = fst_rdata;
                state_next = S_CNT_LD;
            end
            S_CNT_LD:
            begin
                csize_next = cm_rsize;
                cout_next  = cm_rout;
                state_next = S_CNT_E;
            end
            S_CNT_E:
            begin
                ed_raddr = EW'(ccur_reg - LW'(1));
                if (ccur_reg == '0)
                begin
                    cm_we      = 1'b1;
                    vscan_next = vscan_reg + (NW+1)'(1);
                    state_next = S_CNT_V;
                end
                else
                begin
                    state_next = S_CNT_EW;
                end
            end
            S_CNT_EW:
            begin
                ccur_next  = ed_rlink;
                nd_raddr   = NW'(ed_rtgt);
                state_next = tgt_ok ? S_CNT_NW : S_CNT_E;
            end
            S_CNT_NW:
            begin
                if (nd_rcomp != cv_reg)
                begin
                    cout_next = cout_reg + LW'(1);
                end
                state_next = S_CNT_E;
            end
            S_SK:
            begin
                cm_raddr = vscan_reg[NW-1:0];
                if (vscan_reg > {1'b0, ccnt_reg})
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SK_W;
                end
            end
            S_SK_W:
            begin
                if (cm_rout == '0)
                begin
                    sink_next = (sink_reg == 2'd0) ? 2'd1 : 2'd2;
                    last_next = cm_rsize;
                end
                vscan_next = vscan_reg + (NW+1)'(1);
                state_next = S_SK;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_size_next  = (sink_reg == 2'd1) ? FW'(last_reg) : '0;
                    out_drop_next  = drop_reg;
                    fill_next      = '0;
                    drop_next      = 1'b0;
                    clr_next       = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ncount_reg    <= FW'(1);
            clr_reg       <= '0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            vscan_reg     <= '0;
            top_vld_reg   <= 1'b0;
            vcnt_reg      <= '0;
            ccnt_reg      <= '0;
            ssp_reg       <= '0;
            fsp_reg       <= '0;
            sink_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_data;
            end
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            pend_reg      <= pend_next;
            fwd_reg       <= fwd_next;
            vscan_reg     <= vscan_next;
            top_vld_reg   <= top_vld_next;
            vcnt_reg      <= vcnt_next;
            ccnt_reg      <= ccnt_next;
            ssp_reg       <= ssp_next;
            fsp_reg       <= fsp_next;
            sink_reg      <= sink_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_src_reg  <= pend_src_next;
        pend_edge_reg <= pend_edge_next;
        fwd_link_reg  <= fwd_link_next;
        ent_reg       <= ent_next;
        top_node_reg  <= top_node_next;
        top_cur_reg   <= top_cur_next;
        top_low_reg   <= top_low_next;
        top_vis_reg   <= top_vis_next;
        nbr_reg       <= nbr_next;
        cv_reg        <= cv_next;
        ccur_reg      <= ccur_next;
        csize_reg     <= csize_next;
        cout_reg      <= cout_next;
        last_reg      <= last_next;
        out_size_reg  <= out_size_next;
        out_drop_reg  <= out_drop_next;
    end

`ifndef SYNTH
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the result state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_EDGES)
        else $error("edge fill count beyond capacity");

    a_frames_on_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (top_vld_reg && state_reg == S_STEP) |-> fsp_reg < ssp_reg)
        else $error("call frames outrun the search stack");

    a_link_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(in_valid && !in_stall && command == usc_pkg::CMD_ADD))
        else $error("list link pending without an add transaction");
`endif

endmodule

`default_nettype wire
